// ===== rtl/tmst_pkg.sv =====
// Shared types and constants of the tagged mailbox slot table.
package tmst_pkg;

  // Field widths of the item channels and the configuration register, and the reset value of the active slot count.
  localparam int DEST_W      = 8;
  localparam int MSG_W       = 8;
  localparam int IDX_W       = 4;
  localparam int CFG_W       = 5;
  localparam int ACTIVE_RESET = 16;

  // Defaults of the top-level parameters.
  localparam int SLOTS_DEFAULT       = 16;
  localparam int HANDLE_BITS_DEFAULT = 8;

  typedef enum logic {
    KIND_SEND = 1'b0,
    KIND_RECV = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY_FULL = 2'd1,
    ST_BAD_PARAM  = 2'd2
  } status_t;

  // Input beat.
  typedef struct packed {
    kind_t               kind;
    logic [DEST_W-1:0]   dest_id;
    logic [MSG_W-1:0]    msg_handle;
    logic                msg_missing;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    status_t             status;
    logic [MSG_W-1:0]    msg_out;
    logic [IDX_W-1:0]    slot_index;
  } out_beat_t;

  // Request broadcast from the controller to every cell.
  typedef struct packed {
    kind_t               kind;
    logic [DEST_W-1:0]   dest;
    logic [MSG_W-1:0]    handle;
    logic                exec;
  } cell_req_t;

  // Search carry handed from one cell to the next.
  typedef struct packed {
    logic                taken;
    logic [IDX_W-1:0]    idx;
    logic [MSG_W-1:0]    msg;
  } cell_chain_t;

endpackage

// ===== rtl/tmst_stream_if.sv =====
// Valid/ready channel interface carrying one payload beat.
interface tmst_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tagged_mailbox_slot_table_unit.sv =====
// Top level of the tagged mailbox slot table: controller, cell row and result register.
//
// The table is a row of SLOTS cells, each holding one slot's valid mark,
// destination id and message handle. An input beat is first registered in
// req_r and resolved once the result register can take it: the request is
// broadcast to all cells and a one-bit carry runs down the row so that the
// lowest free slot (send) or the lowest valid matching slot (receive) takes
// it, updates itself and hands its index and handle along the row to the
// result register. A new item is accepted once the previous one has moved
// into the result register, even while that result still waits to be taken.
// Slot marks are cleared by reset; there is no clearing pass. The active slot
// count is written through the cfg channel; write it only while no item is in
// flight, the block itself does not enforce this. 0 acts as 1 and values above
// SLOTS act as SLOTS.
module tagged_mailbox_slot_table_unit #(
  parameter int SLOTS       = tmst_pkg::SLOTS_DEFAULT,
  parameter int HANDLE_BITS = tmst_pkg::HANDLE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  tmst_stream_if.sink   in_ch,
  tmst_stream_if.source out_ch,
  tmst_stream_if.sink   cfg_ch
);

  localparam int CntW   = $clog2(SLOTS + 1);
  localparam int StoreW = (HANDLE_BITS < tmst_pkg::MSG_W) ? HANDLE_BITS : tmst_pkg::MSG_W;
  localparam int ActReset = (SLOTS < tmst_pkg::ACTIVE_RESET) ? SLOTS : tmst_pkg::ACTIVE_RESET;
  localparam int IdxW   = tmst_pkg::IDX_W;

  logic                  busy_r;
  tmst_pkg::in_beat_t    req_r;
  logic                  out_valid_r;
  tmst_pkg::out_beat_t   out_data_r;
  logic [CntW-1:0]       act_r;
  logic [CntW-1:0]       act_nxt;
  logic [CntW-1:0]       used_r;
  logic [CntW-1:0]       used_nxt;

  logic                  out_free;
  logic                  go;
  logic                  send_full;
  tmst_pkg::cell_req_t   req;
  tmst_pkg::cell_chain_t chain [SLOTS+1];
  logic [SLOTS-1:0]      in_range;
  logic [SLOTS-1:0]      valid_vec;
  tmst_pkg::out_beat_t   result;

  // Channel handshakes.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign go           = busy_r && out_free;
  assign in_ch.ready  = !busy_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Clamp the written slot count into 1..SLOTS.
  always_comb begin
    if (cfg_ch.data == '0) begin
      act_nxt = CntW'(1);
    end else if (int'(cfg_ch.data) > SLOTS) begin
      act_nxt = CntW'(SLOTS);
    end else begin
      act_nxt = CntW'(int'(cfg_ch.data));
    end
  end

  // Request broadcast to the cells; a send only executes when it is legal.
  assign send_full = (used_r >= act_r);
  always_comb begin
    req.kind   = req_r.kind;
    req.dest   = req_r.dest_id;
    req.handle = req_r.msg_handle;
    if (req_r.kind == tmst_pkg::KIND_SEND) begin
      req.exec = go && !req_r.msg_missing && !send_full;
    end else begin
      req.exec = go;
    end
  end

  // Row of slot cells linked by the search chain.
  assign chain[0] = '0;
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign in_range[i] = (CntW'(i) < act_r);
    tmst_cell #(
      .IDX     (i),
      .STORE_W (StoreW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req),
      .in_range  (in_range[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .valid_o   (valid_vec[i])
    );
  end

  // Result beat and fill count update.
  always_comb begin
    result   = '{status: tmst_pkg::ST_EMPTY_FULL, msg_out: '0, slot_index: '0};
    used_nxt = used_r;
    if (req_r.kind == tmst_pkg::KIND_SEND) begin
      if (req_r.msg_missing) begin
        result.status = tmst_pkg::ST_BAD_PARAM;
      end else if (!send_full && chain[SLOTS].taken) begin
        result.status     = tmst_pkg::ST_OK;
        result.slot_index = chain[SLOTS].idx;
        used_nxt          = used_r + CntW'(1);
      end
    end else if (chain[SLOTS].taken) begin
      result.status     = tmst_pkg::ST_OK;
      result.msg_out    = chain[SLOTS].msg;
      result.slot_index = chain[SLOTS].idx;
      if (used_r != '0) begin
        used_nxt = used_r - CntW'(1);
      end
    end
  end

  // Controller state, fill count and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      act_r       <= CntW'(ActReset);
    end else begin
      if (cfg_ch.valid) begin
        act_r <= act_nxt;
      end
      if (in_ch.valid && !busy_r) begin
        busy_r <= 1'b1;
      end else if (go) begin
        busy_r <= 1'b0;
      end
      if (go) begin
        out_valid_r <= 1'b1;
        used_r      <= used_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && !busy_r) begin
      req_r <= in_ch.data;
    end
    if (go) begin
      out_data_r <= result;
    end
  end

`ifndef SYNTHESIS
  // The fill count always equals the number of occupied slots.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(used_r))
    else $error("fill count differs from occupied slots");

  // The active slot count stays within 1..SLOTS.
  a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r != '0) && (int'(act_r) <= SLOTS))
    else $error("active slot count out of range");

  // A new result only appears after an item was in flight.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result without a pending item");

  // A successful send never lands on a slot outside the active range.
  a_send_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (req.exec && (req.kind == tmst_pkg::KIND_SEND) && chain[SLOTS].taken)
      |=> (int'(out_data_r.slot_index) < int'(act_r)) || (SLOTS > (1 << IdxW)))
    else $error("send filled a slot beyond the active count");
`endif

endmodule

// ===== rtl/tmst_cell.sv =====
// One packet slot of the table together with its link in the search chain.
module tmst_cell #(
  parameter int IDX     = 0,
  parameter int STORE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmst_pkg::cell_req_t   req,
  input  logic                 in_range,
  input  tmst_pkg::cell_chain_t chain_in,
  output tmst_pkg::cell_chain_t chain_out,
  output logic                 valid_o
);

  localparam int MsgW = tmst_pkg::MSG_W;
  localparam int IdxW = tmst_pkg::IDX_W;
  localparam int DestW = tmst_pkg::DEST_W;
  localparam logic [IdxW-1:0] IdxField = IdxW'(IDX % (1 << IdxW));

  logic               valid_r;
  logic [DestW-1:0]   dest_r;
  logic [STORE_W-1:0] msg_r;
  logic               hit;
  logic               grant;

  // A send wants a free slot inside the active range; a receive wants a match.
  always_comb begin
    if (req.kind == tmst_pkg::KIND_SEND) begin
      hit = !valid_r && in_range;
    end else begin
      hit = valid_r && (dest_r == req.dest);
    end
    grant = hit && !chain_in.taken;
  end

  // The first hitting cell claims the request and puts its slot on the chain.
  always_comb begin
    chain_out.taken = chain_in.taken || hit;
    chain_out.idx   = grant ? IdxField : chain_in.idx;
    chain_out.msg   = grant ? MsgW'(msg_r) : chain_in.msg;
  end

  // Valid mark is control state and resets; the payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (grant && req.exec) begin
      valid_r <= (req.kind == tmst_pkg::KIND_SEND);
    end
  end

  always_ff @(posedge clk) begin
    if (grant && req.exec && (req.kind == tmst_pkg::KIND_SEND)) begin
      dest_r <= req.dest;
      msg_r  <= STORE_W'(req.handle);
    end
  end

  assign valid_o = valid_r;

endmodule

// ===== test/tmst_checker.sv =====
// Checker of the mailbox slot table: tracks the slot table, predicts each result beat and compares.
module tmst_checker #(
  parameter int SLOTS = tmst_pkg::SLOTS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  tmst_pkg::in_beat_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  tmst_pkg::out_beat_t        out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [tmst_pkg::CFG_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the slot table and the active slot count.
  logic                        slot_held   [SLOTS];
  logic [tmst_pkg::DEST_W-1:0] slot_tag    [SLOTS];
  logic [tmst_pkg::MSG_W-1:0]  slot_handle [SLOTS];
  int                          fill_count;
  logic [tmst_pkg::CFG_W-1:0]  active_cfg;

  // Results still owed by the block, oldest first.
  tmst_pkg::out_beat_t expected_replies[$];

  // Applies one request to the shadow table and returns the reply it earns.
  function automatic tmst_pkg::out_beat_t mailbox_answer(tmst_pkg::in_beat_t req);
    tmst_pkg::out_beat_t reply;
    int        limit;
    int        i;
    bit        done;
    reply.status     = tmst_pkg::ST_EMPTY_FULL;
    reply.msg_out    = '0;
    reply.slot_index = '0;
    done = 1'b0;
    if (req.kind == tmst_pkg::KIND_SEND) begin
      // A count of zero acts as one; anything past the table depth acts as the depth.
      limit = (active_cfg == 0) ? 1 : ((active_cfg > SLOTS) ? SLOTS : int'(active_cfg));
      if (req.msg_missing) begin
        reply.status = tmst_pkg::ST_BAD_PARAM;
      end else if (fill_count < limit) begin
        for (i = 0; i < limit; i++) begin
          if (!done && !slot_held[i]) begin
            slot_held[i]     = 1'b1;
            slot_tag[i]      = req.dest_id;
            slot_handle[i]   = req.msg_handle;
            fill_count       = fill_count + 1;
            reply.status     = tmst_pkg::ST_OK;
            reply.slot_index = tmst_pkg::IDX_W'(i);
            done = 1'b1;
          end
        end
      end
    end else begin
      // Receives search the whole table, so packets above a shrunk count still leave.
      for (i = 0; i < SLOTS; i++) begin
        if (!done && slot_held[i] && slot_tag[i] == req.dest_id) begin
          slot_held[i]     = 1'b0;
          if (fill_count > 0) fill_count = fill_count - 1;
          reply.status     = tmst_pkg::ST_OK;
          reply.msg_out    = slot_handle[i];
          reply.slot_index = tmst_pkg::IDX_W'(i);
          done = 1'b1;
        end
      end
    end
    return reply;
  endfunction

  // Reports one field that differs from its prediction.
  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      fail_count = fail_count + 1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Result beats are checked before the input beat of the same edge is predicted.
  always @(posedge clk) begin
    tmst_pkg::out_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_held[i] = 1'b0;
      fill_count  = 0;
      active_cfg  = tmst_pkg::CFG_W'(tmst_pkg::ACTIVE_RESET);
      fail_count  = 0;
      expected_replies.delete();
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: result beat with nothing expected, actual status %0d msg %0d slot %0d",
                   $time, out_data.status, out_data.msg_out, out_data.slot_index);
        end else begin
          want = expected_replies.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("msg_out", want.msg_out, out_data.msg_out);
          check_field("slot_index", want.slot_index, out_data.slot_index);
        end
      end
      if (cfg_valid && cfg_ready) active_cfg = cfg_data;
      if (in_valid && in_ready) expected_replies.push_back(mailbox_answer(in_data));
      outstanding = expected_replies.size();
    end
  end

endmodule

// ===== test/tagged_mailbox_slot_table_unit_test.sv =====
// Top of the mailbox slot table test: clock, reset, request and register stimulus, verdict.
module tagged_mailbox_slot_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = tmst_pkg::SLOTS_DEFAULT;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_BEATS = 118;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   calm = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;

  tmst_stream_if #(.T(tmst_pkg::in_beat_t))            in_ch();
  tmst_stream_if #(.T(tmst_pkg::out_beat_t))           out_ch();
  tmst_stream_if #(.T(logic [tmst_pkg::CFG_W-1:0]))    cfg_ch();

  tagged_mailbox_slot_table_unit #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (tmst_pkg::HANDLE_BITS_DEFAULT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tmst_checker #(.SLOTS(SLOTS)) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .fail_count  (fail_count),
    .outstanding (pending)
  );

  always #5 clk = ~clk;

  // The result side stalls about a quarter of the time, never while calm is set.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic tmst_pkg::in_beat_t make_request(tmst_pkg::kind_t kind, int dest,
                                                      int handle, bit missing);
    tmst_pkg::in_beat_t b;
    b.kind        = kind;
    b.dest_id     = tmst_pkg::DEST_W'(dest);
    b.msg_handle  = tmst_pkg::MSG_W'(handle);
    b.msg_missing = missing;
    return b;
  endfunction

  // Random request: mostly a few shared ids so that receives find packets.
  function automatic tmst_pkg::in_beat_t random_request(int send_pct);
    logic [tmst_pkg::DEST_W-1:0] tag_pool [4];
    tmst_pkg::in_beat_t b;
    tag_pool = '{8'h00, 8'h3c, 8'hc3, 8'hff};
    b.kind = ($urandom_range(0, 99) < send_pct) ? tmst_pkg::KIND_SEND : tmst_pkg::KIND_RECV;
    if ($urandom_range(0, 99) < 85) b.dest_id = tag_pool[$urandom_range(0, 3)];
    else b.dest_id = tmst_pkg::DEST_W'($urandom);
    b.msg_handle  = tmst_pkg::MSG_W'($urandom);
    b.msg_missing = ($urandom_range(0, 99) < 8);
    return b;
  endfunction

  // Drives one request beat; entered and left at a falling edge, valid left high.
  task automatic push_request(input tmst_pkg::in_beat_t b);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Holds requests back until every owed result has arrived.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the active slot count once the block is idle.
  task automatic set_active_slots(input logic [tmst_pkg::CFG_W-1:0] value);
    hold_until_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int phase_slots [8];
    int send_pct;
    phase_slots = '{16, 3, 31, 8, 1, 20, 0, 12};
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;

    // Reset is held and then released at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, missing message, extreme ids and handles, freed slot.
    set_active_slots(tmst_pkg::CFG_W'(16));
    push_request(make_request(tmst_pkg::KIND_RECV, 0, 0, 1'b0));
    push_request(make_request(tmst_pkg::KIND_SEND, 7, 9, 1'b1));
    push_request(make_request(tmst_pkg::KIND_SEND, 0, 0, 1'b0));
    push_request(make_request(tmst_pkg::KIND_SEND, 255, 255, 1'b0));
    push_request(make_request(tmst_pkg::KIND_RECV, 255, 0, 1'b0));
    push_request(make_request(tmst_pkg::KIND_RECV, 255, 0, 1'b0));
    push_request(make_request(tmst_pkg::KIND_RECV, 0, 255, 1'b1));

    // A one-slot table fills at once; a missing message still reports a bad parameter.
    set_active_slots(tmst_pkg::CFG_W'(1));
    push_request(make_request(tmst_pkg::KIND_SEND, 5, 8'ha5, 1'b0));
    push_request(make_request(tmst_pkg::KIND_SEND, 6, 8'h5a, 1'b0));
    push_request(make_request(tmst_pkg::KIND_SEND, 6, 8'h5a, 1'b1));
    push_request(make_request(tmst_pkg::KIND_RECV, 5, 0, 1'b0));

    // A count of zero behaves as one.
    set_active_slots(tmst_pkg::CFG_W'(0));
    push_request(make_request(tmst_pkg::KIND_SEND, 1, 1, 1'b0));
    push_request(make_request(tmst_pkg::KIND_SEND, 2, 2, 1'b0));

    // Shrinking below the fill level: sends are refused, receives still reach high slots.
    set_active_slots(tmst_pkg::CFG_W'(4));
    push_request(make_request(tmst_pkg::KIND_SEND, 2, 3, 1'b0));
    push_request(make_request(tmst_pkg::KIND_SEND, 3, 4, 1'b0));
    set_active_slots(tmst_pkg::CFG_W'(2));
    push_request(make_request(tmst_pkg::KIND_SEND, 4, 5, 1'b0));
    push_request(make_request(tmst_pkg::KIND_RECV, 3, 0, 1'b0));
    push_request(make_request(tmst_pkg::KIND_RECV, 1, 0, 1'b0));
    push_request(make_request(tmst_pkg::KIND_SEND, 4, 5, 1'b0));

    // Counts past the table depth behave as the depth.
    set_active_slots(tmst_pkg::CFG_W'(31));
    push_request(make_request(tmst_pkg::KIND_SEND, 9, 6, 1'b0));
    push_request(make_request(tmst_pkg::KIND_RECV, 2, 0, 1'b0));
    push_request(make_request(tmst_pkg::KIND_RECV, 4, 0, 1'b0));
    push_request(make_request(tmst_pkg::KIND_RECV, 9, 0, 1'b0));

    // Random phases, each under its own active slot count.
    phase_slots[7] = $urandom_range(0, 31);
    for (int p = 0; p < 8; p++) begin
      set_active_slots(tmst_pkg::CFG_W'(phase_slots[p]));
      calm = (p == 2);
      send_pct = 50;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Fill and drain in bursts so the table swings between empty and full.
        if (n % 16 == 0) send_pct = $urandom_range(25, 75);
        if (p == 4 && n == 60) hold_until_drained();
        push_request(random_request(send_pct));
      end
      calm = 1'b0;
    end

    // Drain the last results, then give the verdict.
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
